// ----- rtl/biphase_rfid_frame_decoder_unit_assert.svh -----
// assertion macros for the biphase frame decoder checker
// both macros sample on the rising edge and are disabled while reset is low
`ifndef BIPHASE_RFID_FRAME_DECODER_UNIT_ASSERT_SVH
`define BIPHASE_RFID_FRAME_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define BFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfd assertion failed");

// next-cycle implication
`define BFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfd assertion failed");

`endif

// ----- rtl/bfd_pkg.sv -----
// ----------------------------------------------------------------------------
// bfd_pkg
// shared types and constants of the biphase card frame decoder
// ----------------------------------------------------------------------------
package bfd_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int DUR_W       = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_MIN = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_MAX = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_MIN  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_MAX  = 4'd3;

    localparam logic [DUR_W-1:0] SHORT_MIN_RST = 16'd136;
    localparam logic [DUR_W-1:0] SHORT_MAX_RST = 16'd376;
    localparam logic [DUR_W-1:0] LONG_MIN_RST  = 16'd392;
    localparam logic [DUR_W-1:0] LONG_MAX_RST  = 16'd632;

    // frame layout
    localparam int WIN_BITS    = 96;
    localparam int DEC_BYTES   = 9;
    localparam int DEC_BITS    = 72;
    localparam int GROUPS      = 18;
    localparam logic [5:0] PREAMBLE = 6'b111110;
    localparam logic [5:0] LEN_26   = 6'd26;
    localparam logic [5:0] LEN_36   = 6'd36;

    typedef enum logic [1:0] {
        PULSE_SHORT,
        PULSE_LONG,
        PULSE_BAD
    } pulse_class_t;

    typedef struct packed {
        logic [DUR_W-1:0] short_min;
        logic [DUR_W-1:0] short_max;
        logic [DUR_W-1:0] long_min;
        logic [DUR_W-1:0] long_max;
    } thresh_t;

    // item sitting behind the bit slicer, the window holds its state
    typedef struct packed {
        logic valid;
        logic pushed;
    } slice_t;

    typedef struct packed {
        logic        frame_valid;
        logic        format_36;
        logic [13:0] facility_code;
        logic [15:0] card_number;
        logic [15:0] profile_word;
        logic [7:0]  xor_key;
        logic [1:0]  check_digits;
    } result_t;

endpackage

// ----- rtl/bfd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bfd_cfg_regs
// pulse window threshold registers with their write decoder
// ----------------------------------------------------------------------------
module bfd_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bfd_pkg::DUR_W-1:0]         cfg_data,
    output bfd_pkg::thresh_t                  thresh
);

    bfd_pkg::thresh_t thresh_reg;
    bfd_pkg::thresh_t thresh_next;

    assign cfg_ready = 1'b1;
    assign thresh    = thresh_reg;

    // index decode, unknown indexes are dropped
    always_comb
    begin
        thresh_next = thresh_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                bfd_pkg::REG_SHORT_MIN: thresh_next.short_min = cfg_data;
                bfd_pkg::REG_SHORT_MAX: thresh_next.short_max = cfg_data;
                bfd_pkg::REG_LONG_MIN:  thresh_next.long_min  = cfg_data;
                bfd_pkg::REG_LONG_MAX:  thresh_next.long_max  = cfg_data;
                default:                thresh_next = thresh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.short_min <= bfd_pkg::SHORT_MIN_RST;
            thresh_reg.short_max <= bfd_pkg::SHORT_MAX_RST;
            thresh_reg.long_min  <= bfd_pkg::LONG_MIN_RST;
            thresh_reg.long_max  <= bfd_pkg::LONG_MAX_RST;
        end
        else
        begin
            thresh_reg <= thresh_next;
        end
    end

endmodule

// ----- rtl/bfd_bit_slicer.sv -----
// ----------------------------------------------------------------------------
// bfd_bit_slicer
// input register, pulse classification, half-bit pairing and bit window
// ----------------------------------------------------------------------------
module bfd_bit_slicer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bfd_pkg::DUR_W-1:0]         pulse_duration,
    input  bfd_pkg::thresh_t                  thresh,
    input  logic                              slice_ready,
    output bfd_pkg::slice_t                   slice,
    output logic [bfd_pkg::WIN_BITS-1:0]      window
);

    logic                          v0_reg;
    logic                          v0_next;
    logic [bfd_pkg::DUR_W-1:0]     dur_reg;
    logic                          v1_reg;
    logic                          v1_next;
    logic                          pushed_reg;
    logic                          pushed_next;
    logic                          pend_reg;
    logic                          pend_next;
    logic [bfd_pkg::WIN_BITS-1:0]  win_reg;
    logic [bfd_pkg::WIN_BITS-1:0]  win_next;
    logic                          s1_free;
    logic                          s0_load;
    logic                          in_xfer;
    bfd_pkg::pulse_class_t         pclass;

    // stage handshake
    assign s1_free  = !v1_reg || slice_ready;
    assign s0_load  = v0_reg && s1_free;
    assign in_ready = !v0_reg || s1_free;
    assign in_xfer  = in_valid && in_ready;

    assign slice.valid  = v1_reg;
    assign slice.pushed = pushed_reg;
    assign window       = win_reg;

    // pulse classification, short wins where the windows overlap
    always_comb
    begin
        if (dur_reg >= thresh.short_min && dur_reg <= thresh.short_max)
            pclass = bfd_pkg::PULSE_SHORT;
        else if (dur_reg >= thresh.long_min && dur_reg <= thresh.long_max)
            pclass = bfd_pkg::PULSE_LONG;
        else
            pclass = bfd_pkg::PULSE_BAD;
    end

    // half-bit pairing and window shift
    always_comb
    begin
        pend_next   = pend_reg;
        win_next    = win_reg;
        pushed_next = pushed_reg;
        if (s0_load)
        begin
            pushed_next = 1'b0;
            unique case (pclass)
                bfd_pkg::PULSE_SHORT:
                begin
                    if (!pend_reg)
                    begin
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        win_next    = {win_reg[bfd_pkg::WIN_BITS-2:0], 1'b1};
                        pushed_next = 1'b1;
                        pend_next   = 1'b0;
                    end
                end
                bfd_pkg::PULSE_LONG:
                begin
                    if (!pend_reg)
                    begin
                        win_next    = {win_reg[bfd_pkg::WIN_BITS-2:0], 1'b0};
                        pushed_next = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end
                default:
                begin
                    pend_next = 1'b0;
                end
            endcase
        end
    end

    // stage valid bits
    always_comb
    begin
        if (in_xfer)
            v0_next = 1'b1;
        else if (s0_load)
            v0_next = 1'b0;
        else
            v0_next = v0_reg;

        if (s0_load)
            v1_next = 1'b1;
        else if (slice_ready)
            v1_next = 1'b0;
        else
            v1_next = v1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg     <= 1'b0;
            v1_reg     <= 1'b0;
            pushed_reg <= 1'b0;
            pend_reg   <= 1'b0;
            win_reg    <= '0;
        end
        else
        begin
            v0_reg     <= v0_next;
            v1_reg     <= v1_next;
            pushed_reg <= pushed_next;
            pend_reg   <= pend_next;
            win_reg    <= win_next;
        end
    end

    // captured duration
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            dur_reg <= pulse_duration;
    end

endmodule

// ----- rtl/bfd_frame_check.sv -----
// ----------------------------------------------------------------------------
// bfd_frame_check
// frame checks on the bit window, field extraction and result register
// ----------------------------------------------------------------------------
module bfd_frame_check (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bfd_pkg::slice_t                   slice,
    input  logic [bfd_pkg::WIN_BITS-1:0]      window,
    output logic                              slice_ready,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bfd_pkg::result_t                  result
);

    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    bfd_pkg::result_t                      result_reg;
    bfd_pkg::result_t                      result_next;
    logic                                  take;
    logic                                  preamble_ok;
    logic                                  stuff_ok;
    logic                                  parity_ok;
    logic                                  is_26;
    logic                                  is_36;
    logic [5:0]                            len_code;
    logic [bfd_pkg::DEC_BYTES-1:0][7:0]    raw;
    logic [bfd_pkg::DEC_BYTES-1:0][7:0]    dec;
    logic [bfd_pkg::DEC_BITS-1:0]          stream;

    assign slice_ready = !out_valid_reg || out_ready;
    assign take        = slice.valid && slice_ready;
    assign out_valid   = out_valid_reg;
    assign result      = result_reg;

    // preamble and zero stuffing bit in every group of five
    always_comb
    begin
        preamble_ok = (window[bfd_pkg::WIN_BITS-1 -: 6] == bfd_pkg::PREAMBLE);
        stuff_ok    = 1'b1;
        for (int g = 0; g < bfd_pkg::GROUPS; g++)
        begin
            if (window[bfd_pkg::WIN_BITS-1-(10+5*g)])
                stuff_ok = 1'b0;
        end
    end

    // regroup data bits into bytes, reversed within each byte
    always_comb
    begin
        for (int j = 0; j < bfd_pkg::DEC_BITS; j++)
            raw[j/8][j%8] = window[bfd_pkg::WIN_BITS-1-(6+5*(j/4)+(j%4))];
    end

    // descramble with the first byte
    always_comb
    begin
        dec[0] = raw[0];
        for (int k = 1; k < bfd_pkg::DEC_BYTES; k++)
            dec[k] = raw[k] ^ raw[0];
    end

    // msb-first bit stream, stream bit i sits at index 71-i
    always_comb
    begin
        for (int i = 0; i < bfd_pkg::DEC_BITS; i++)
            stream[bfd_pkg::DEC_BITS-1-i] = dec[i/8][7-(i%8)];
    end

    // length code and wiegand parity
    always_comb
    begin
        len_code = stream[63:58];
        is_26    = (len_code == bfd_pkg::LEN_26);
        is_36    = (len_code == bfd_pkg::LEN_36);
        if (is_26)
            parity_ok = (stream[39] == ^stream[38:27]) && (stream[14] == ~^stream[26:15]);
        else if (is_36)
            parity_ok = (stream[39] == ^stream[38:22]) && (stream[4] == ~^stream[21:5]);
        else
            parity_ok = 1'b0;
    end

    // result fields, all zero unless a pushed bit completed a good frame
    always_comb
    begin
        result_next = '0;
        if (slice.pushed && preamble_ok && stuff_ok && parity_ok)
        begin
            result_next.frame_valid  = 1'b1;
            result_next.format_36    = is_36;
            result_next.profile_word = stream[55:40];
            result_next.xor_key      = dec[0];
            result_next.check_digits = stream[57:56];
            if (is_36)
            begin
                result_next.facility_code = stream[38:25];
                result_next.card_number   = stream[20:5];
            end
            else
            begin
                result_next.facility_code = {6'd0, stream[38:31]};
                result_next.card_number   = stream[30:15];
            end
        end
    end

    // output register valid
    always_comb
    begin
        if (take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            result_reg <= result_next;
    end

endmodule

// ----- rtl/biphase_rfid_frame_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// biphase_rfid_frame_decoder_unit
// biphase pulse-width decoder for 26- and 36-bit wiegand card frames
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  input     in_valid / in_ready   pulse_duration
//  result    out_valid / out_ready frame_valid .. check_digits
//  config    cfg_valid / cfg_ready cfg_index, cfg_data
//
//  one result per input transfer, one transfer per cycle sustained while out_ready stays high
//  after its input transfer a result passes the input register, the
//  window update register and the result register, in that order
//  the rate is set by the half-bit flag and 96-bit window loop
//  reset clears all valid bits, the pending flag and the window, thresholds reload
//  each stage has its own ready, so bubbles fill while a result is held
// ----------------------------------------------------------------------------
module biphase_rfid_frame_decoder_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [15:0]                       pulse_duration,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              frame_valid,
    output logic                              format_36,
    output logic [13:0]                       facility_code,
    output logic [15:0]                       card_number,
    output logic [15:0]                       profile_word,
    output logic [7:0]                        xor_key,
    output logic [1:0]                        check_digits,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [15:0]                       cfg_data
);

    bfd_pkg::thresh_t                  thresh;
    bfd_pkg::slice_t                   slice;
    bfd_pkg::result_t                  result;
    logic [bfd_pkg::WIN_BITS-1:0]      window;
    logic                              slice_ready;

    bfd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thresh    (thresh)
    );

    bfd_bit_slicer u_slicer (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pulse_duration (pulse_duration),
        .thresh         (thresh),
        .slice_ready    (slice_ready),
        .slice          (slice),
        .window         (window)
    );

    bfd_frame_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .slice       (slice),
        .window      (window),
        .slice_ready (slice_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (result)
    );

    // result fields
    assign frame_valid   = result.frame_valid;
    assign format_36     = result.format_36;
    assign facility_code = result.facility_code;
    assign card_number   = result.card_number;
    assign profile_word  = result.profile_word;
    assign xor_key       = result.xor_key;
    assign check_digits  = result.check_digits;

endmodule

// ----- rtl/bfd_port_checker.sv -----
// ----------------------------------------------------------------------------
// bfd_port_checker
// port-level assertions for the biphase frame decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "biphase_rfid_frame_decoder_unit_assert.svh"

module bfd_port_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        frame_valid,
    input  logic        format_36,
    input  logic [13:0] facility_code,
    input  logic [15:0] card_number,
    input  logic [15:0] profile_word,
    input  logic [7:0]  xor_key,
    input  logic [1:0]  check_digits
);

    // a held result keeps its fields
    `BFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(frame_valid) && $stable(card_number) && $stable(facility_code))

    // a failed or idle item reports all zeros
    `BFD_ASSERT_SAME(a_fail_zero, clk, rst_n, out_valid && !frame_valid, !format_36 && facility_code == 14'd0 && card_number == 16'd0 && profile_word == 16'd0 && xor_key == 8'd0 && check_digits == 2'd0)

    // a 26-bit card has only an 8-bit facility code
    `BFD_ASSERT_SAME(a_fc26_width, clk, rst_n, out_valid && frame_valid && !format_36, facility_code[13:8] == 6'd0)

    // with the result register empty the pipeline can always take an item
    `BFD_ASSERT_SAME(a_empty_ready, clk, rst_n, !out_valid, in_ready)

endmodule

bind biphase_rfid_frame_decoder_unit bfd_port_checker u_bfd_port_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_valid   (frame_valid),
    .format_36     (format_36),
    .facility_code (facility_code),
    .card_number   (card_number),
    .profile_word  (profile_word),
    .xor_key       (xor_key),
    .check_digits  (check_digits)
);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the biphase card frame decoder: pulse durations are
// classified against the threshold registers, decoded bits are pushed into a
// local copy of the 96-bit window and every result transfer is compared with
// the locally decoded fields; encoded 26- and 36-bit frames drive the decoder
// through all of its checks under several threshold settings
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY = 6;
    localparam int IDLE_LIMIT   = 2000;
    localparam logic [bfd_pkg::CFG_INDEX_W-1:0] REG_FIRST_UNUSED =
        bfd_pkg::REG_LONG_MAX + 4'd1;
    localparam logic [bfd_pkg::CFG_INDEX_W-1:0] REG_LAST_UNUSED  = '1;

    logic                            clk            = 1'b0;
    logic                            rst_n          = 1'b0;
    logic                            in_valid       = 1'b0;
    logic                            in_ready;
    logic [15:0]                     pulse_duration = '0;
    logic                            out_valid;
    logic                            out_ready      = 1'b0;
    logic                            frame_valid;
    logic                            format_36;
    logic [13:0]                     facility_code;
    logic [15:0]                     card_number;
    logic [15:0]                     profile_word;
    logic [7:0]                      xor_key;
    logic [1:0]                      check_digits;
    logic                            cfg_valid      = 1'b0;
    logic                            cfg_ready;
    logic [bfd_pkg::CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [15:0]                     cfg_data       = '0;

    // local copy of decoder state and thresholds
    logic        half_pending;
    logic [0:95] bit_window;
    logic [15:0] thr_short_min;
    logic [15:0] thr_short_max;
    logic [15:0] thr_long_min;
    logic [15:0] thr_long_max;

    bfd_pkg::result_t predicted_results[$];

    bit send_gaps_on = 1'b1;
    bit recv_gaps_on = 1'b1;

    int errors        = 0;
    int pulses_sent   = 0;
    int results_seen  = 0;
    int frames_26     = 0;
    int frames_36     = 0;
    int settings_used = 0;
    int idle_cycles   = 0;

    biphase_rfid_frame_decoder_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pulse_duration (pulse_duration),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_valid    (frame_valid),
        .format_36      (format_36),
        .facility_code  (facility_code),
        .card_number    (card_number),
        .profile_word   (profile_word),
        .xor_key        (xor_key),
        .check_digits   (check_digits),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // clock
    always #10 clk = ~clk;

    // msb-first slice of the decoded bit stream
    function automatic logic [63:0] take_bits(input logic [0:71] s, input int start,
                                              input int len);
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < len; k++)
        begin
            v = {v[62:0], s[start+k]};
        end
        return v;
    endfunction

    // xor of value bits lo .. hi-1
    function automatic logic parity_of(input logic [63:0] v, input int lo, input int hi);
        logic p;
        p = 1'b0;
        for (int i = lo; i < hi; i++)
        begin
            p = p ^ v[i];
        end
        return p;
    endfunction

    // run all frame checks on a window, zero fields when any check fails
    function automatic bfd_pkg::result_t decode_window(input logic [0:95] w);
        bfd_pkg::result_t r;
        logic [7:0]       d [0:8];
        logic [0:71]      ds;
        logic [5:0]       flen;
        logic [63:0]      pay;
        int               total;
        int               split;
        r = '0;
        if (w[0:5] != bfd_pkg::PREAMBLE)
            return r;
        for (int g = 0; g < bfd_pkg::GROUPS; g++)
        begin
            if (w[6 + 5*g + 4])
                return r;
        end
        // unstuff and bit-reverse each byte
        for (int j = 0; j < bfd_pkg::DEC_BITS; j++)
        begin
            d[j/8][j%8] = w[6 + 5*(j/4) + (j%4)];
        end
        for (int i = 1; i < bfd_pkg::DEC_BYTES; i++)
        begin
            d[i] = d[i] ^ d[0];
        end
        for (int i = 0; i < bfd_pkg::DEC_BITS; i++)
        begin
            ds[i] = d[i/8][7 - (i%8)];
        end
        flen = ds[8:13];
        if (flen == bfd_pkg::LEN_26)
        begin
            total = 24;
            split = 12;
        end
        else if (flen == bfd_pkg::LEN_36)
        begin
            total = 34;
            split = 17;
        end
        else
            return r;
        pay = take_bits(ds, 33, total);
        if (ds[32] != parity_of(pay, split, total))
            return r;
        if (ds[33 + total] != ~parity_of(pay, 0, split))
            return r;
        r.frame_valid = 1'b1;
        r.format_36   = (flen == bfd_pkg::LEN_36);
        if (flen == bfd_pkg::LEN_26)
        begin
            r.facility_code = 14'(take_bits(ds, 33, 8));
            r.card_number   = 16'(take_bits(ds, 41, 16));
        end
        else
        begin
            r.facility_code = 14'(take_bits(ds, 33, 14));
            r.card_number   = 16'(take_bits(ds, 51, 16));
        end
        r.profile_word = 16'(take_bits(ds, 16, 16));
        r.xor_key      = d[0];
        r.check_digits = 2'(take_bits(ds, 14, 2));
        return r;
    endfunction

    // classify one pulse, update half-bit flag and window
    function automatic bfd_pkg::result_t decode_pulse(input logic [15:0] dur);
        logic pushed;
        pushed = 1'b0;
        if (dur >= thr_short_min && dur <= thr_short_max)
        begin
            if (!half_pending)
                half_pending = 1'b1;
            else
            begin
                bit_window   = {bit_window[1:95], 1'b1};
                pushed       = 1'b1;
                half_pending = 1'b0;
            end
        end
        else if (dur >= thr_long_min && dur <= thr_long_max)
        begin
            if (!half_pending)
            begin
                bit_window = {bit_window[1:95], 1'b0};
                pushed     = 1'b1;
            end
            else
                half_pending = 1'b0;
        end
        else
            half_pending = 1'b0;
        if (!pushed)
            return '0;
        return decode_window(bit_window);
    endfunction

    // build a window for a frame with random content, correct structure unless bad_len
    function automatic logic [0:95] encode_frame(input logic fmt36, input logic bad_len);
        logic [95:0] rnd;
        logic [0:71] ds;
        logic [7:0]  d [0:8];
        logic [0:95] w;
        logic [63:0] pay;
        int          total;
        int          split;
        int          j;
        rnd   = {$urandom(), $urandom(), $urandom()};
        ds    = rnd[71:0];
        total = fmt36 ? 34 : 24;
        split = fmt36 ? 17 : 12;
        ds[8:13] = fmt36 ? bfd_pkg::LEN_36 : bfd_pkg::LEN_26;
        if (bad_len)
            ds[8:13] = 6'($urandom_range(0, 63));
        pay = take_bits(ds, 33, total);
        ds[32]         = parity_of(pay, split, total);
        ds[33 + total] = ~parity_of(pay, 0, split);
        for (int i = 0; i < bfd_pkg::DEC_BYTES; i++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                d[i][7-k] = ds[8*i + k];
            end
        end
        for (int i = 1; i < bfd_pkg::DEC_BYTES; i++)
        begin
            d[i] = d[i] ^ d[0];
        end
        w[0:5] = bfd_pkg::PREAMBLE;
        for (int g = 0; g < bfd_pkg::GROUPS; g++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                j = 4*g + k;
                w[6 + 5*g + k] = d[j/8][j%8];
            end
            w[6 + 5*g + 4] = 1'b0;
        end
        return w;
    endfunction

    function automatic logic [15:0] pick_short();
        return 16'($urandom_range(thr_short_min, thr_short_max));
    endfunction

    function automatic logic [15:0] pick_long();
        return 16'($urandom_range(thr_long_min, thr_long_max));
    endfunction

    // a duration outside both windows when one is found quickly
    function automatic logic [15:0] pick_bad();
        logic [15:0] v;
        v = 16'($urandom_range(0, 65535));
        for (int t = 0; t < 16; t++)
        begin
            if ((v < thr_short_min || v > thr_short_max) &&
                (v < thr_long_min || v > thr_long_max))
                return v;
            v = 16'($urandom_range(0, 65535));
        end
        return v;
    endfunction

    // input transfer monitor, predicts the result of each accepted pulse
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            predicted_results.push_back(decode_pulse(pulse_duration));
            pulses_sent++;
        end
    end

    // config transfer monitor
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bfd_pkg::REG_SHORT_MIN: thr_short_min = cfg_data;
                bfd_pkg::REG_SHORT_MAX: thr_short_max = cfg_data;
                bfd_pkg::REG_LONG_MIN:  thr_long_min  = cfg_data;
                bfd_pkg::REG_LONG_MAX:  thr_long_max  = cfg_data;
                default:                ;
            endcase
        end
    end

    task automatic report_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        bfd_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (predicted_results.size() == 0)
            begin
                $display("%0t unexpected result transfer, nothing predicted", $time);
                errors++;
            end
            else
            begin
                want = predicted_results.pop_front();
                if (want.frame_valid)
                begin
                    if (want.format_36)
                        frames_36++;
                    else
                        frames_26++;
                end
                report_field("frame_valid", 16'(want.frame_valid), 16'(frame_valid));
                report_field("format_36", 16'(want.format_36), 16'(format_36));
                report_field("facility_code", 16'(want.facility_code), 16'(facility_code));
                report_field("card_number", want.card_number, card_number);
                report_field("profile_word", want.profile_word, profile_word);
                report_field("xor_key", 16'(want.xor_key), 16'(xor_key));
                report_field("check_digits", 16'(want.check_digits), 16'(check_digits));
            end
        end
    end

    // result receiver with random stalls
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = recv_gaps_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // one pulse transfer, valid stays high into the next pulse when no gap
    task automatic send_pulse(input logic [15:0] dur);
        int gap;
        gap = send_gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        pulse_duration <= dur;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // stop sending and wait until every predicted result has arrived
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bfd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [15:0] smin, input logic [15:0] smax,
                                  input logic [15:0] lmin, input logic [15:0] lmax);
        wait_idle();
        write_reg(bfd_pkg::REG_SHORT_MIN, smin);
        write_reg(bfd_pkg::REG_SHORT_MAX, smax);
        write_reg(bfd_pkg::REG_LONG_MIN, lmin);
        write_reg(bfd_pkg::REG_LONG_MAX, lmax);
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // send every bit of a window as biphase pulses
    task automatic send_frame(input logic [0:95] w);
        wait_idle();
        if (half_pending)
            send_pulse(pick_long());
        for (int i = 0; i < bfd_pkg::WIN_BITS; i++)
        begin
            if (w[i])
            begin
                send_pulse(pick_short());
                send_pulse(pick_short());
            end
            else
                send_pulse(pick_long());
        end
    endtask

    // window edges at reset thresholds, pending-short cases
    task automatic test_pulse_windows();
        send_pulse(16'd0);
        send_pulse(16'hFFFF);
        send_pulse(bfd_pkg::SHORT_MIN_RST - 16'd1);
        send_pulse(bfd_pkg::SHORT_MIN_RST);
        send_pulse(bfd_pkg::SHORT_MAX_RST);
        send_pulse(bfd_pkg::SHORT_MAX_RST + 16'd1);
        send_pulse(bfd_pkg::LONG_MIN_RST - 16'd1);
        send_pulse(bfd_pkg::LONG_MIN_RST);
        send_pulse(bfd_pkg::LONG_MAX_RST);
        send_pulse(bfd_pkg::LONG_MAX_RST + 16'd1);
        // long after a pending short clears it without a bit
        send_pulse(16'd200);
        send_pulse(16'd500);
        send_pulse(16'd500);
    endtask

    // writes to indexes past the last register change nothing
    task automatic test_ignored_index();
        wait_idle();
        write_reg(REG_FIRST_UNUSED, 16'h0000);
        write_reg(REG_LAST_UNUSED, 16'hFFFF);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_pulse(bfd_pkg::SHORT_MIN_RST);
        send_pulse(bfd_pkg::SHORT_MAX_RST);
        send_pulse(bfd_pkg::LONG_MAX_RST);
    endtask

    // overlapping windows, short test wins
    task automatic test_overlap();
        set_thresholds(16'd100, 16'd500, 16'd400, 16'd800);
        send_pulse(16'd450);
        send_pulse(16'd450);
        send_pulse(16'd700);
        send_pulse(16'd400);
        send_pulse(16'd500);
        send_pulse(16'd800);
    endtask

    // encoded frames with random content under several threshold settings
    task automatic test_frames();
        logic [15:0] smin;
        logic [15:0] smax;
        logic [15:0] lmin;
        logic [15:0] lmax;
        logic [0:95] w;
        int          kind;
        int          noise;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_thresholds(bfd_pkg::SHORT_MIN_RST, bfd_pkg::SHORT_MAX_RST,
                                  bfd_pkg::LONG_MIN_RST, bfd_pkg::LONG_MAX_RST);
                3: set_thresholds(16'd0, 16'd32767, 16'd32768, 16'd65534);
                4: set_thresholds(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
                default:
                begin
                    smin = 16'($urandom_range(1, 2000));
                    smax = smin + 16'($urandom_range(0, 2000));
                    lmin = smax + 16'($urandom_range(1, 100));
                    lmax = lmin + 16'($urandom_range(0, 3000));
                    set_thresholds(smin, smax, lmin, lmax);
                end
            endcase
            for (int f = 0; f < 2; f++)
            begin
                send_gaps_on = ($urandom_range(0, 3) != 0);
                recv_gaps_on = ($urandom_range(0, 3) != 0);
                kind = $urandom_range(0, 5);
                w = encode_frame(1'($urandom_range(0, 1)), kind == 1);
                // a stray flipped bit may break one of the checks
                if (kind == 0)
                    w[$urandom_range(0, 95)] ^= 1'b1;
                noise = $urandom_range(0, 6);
                for (int n = 0; n < noise; n++)
                begin
                    case ($urandom_range(0, 2))
                        0:       send_pulse(pick_short());
                        1:       send_pulse(pick_long());
                        default: send_pulse(pick_bad());
                    endcase
                end
                send_frame(w);
            end
        end
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
    endtask

    // full-range durations under degenerate and default windows
    task automatic test_noise();
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       set_thresholds(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
                1:       set_thresholds(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
                default: set_thresholds(bfd_pkg::SHORT_MIN_RST, bfd_pkg::SHORT_MAX_RST,
                                        bfd_pkg::LONG_MIN_RST, bfd_pkg::LONG_MAX_RST);
            endcase
            for (int n = 0; n < 80; n++)
            begin
                if (n % 20 == 0)
                    send_gaps_on = ($urandom_range(0, 2) != 0);
                case ($urandom_range(0, 3))
                    0:       send_pulse(pick_short());
                    1:       send_pulse(pick_long());
                    default: send_pulse(16'($urandom_range(0, 65535)));
                endcase
            end
        end
        send_gaps_on = 1'b1;
    endtask

    // main sequence
    initial
    begin
        half_pending  = 1'b0;
        bit_window    = '0;
        thr_short_min = bfd_pkg::SHORT_MIN_RST;
        thr_short_max = bfd_pkg::SHORT_MAX_RST;
        thr_long_min  = bfd_pkg::LONG_MIN_RST;
        thr_long_max  = bfd_pkg::LONG_MAX_RST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pulse_windows();
        test_ignored_index();
        test_overlap();
        test_frames();
        test_noise();
        wait_idle();

        $display("covered %0d pulses and %0d result transfers over %0d threshold settings",
                 pulses_sent, results_seen, settings_used);
        $display("decoded %0d good 26-bit and %0d good 36-bit frames", frames_26, frames_36);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/bfd_pkg.sv
rtl/bfd_cfg_regs.sv
rtl/bfd_bit_slicer.sv
rtl/bfd_frame_check.sv
rtl/biphase_rfid_frame_decoder_unit.sv
rtl/bfd_port_checker.sv
tb/testbench.sv
